FILE: hdl/fcpq_pkg.sv
// shared types and constants of the four class priority queue
package fcpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int HANDLE_BITS = 16;
   localparam int NUM_CLASSES = 4;

   localparam int CLASS_BITS  = $clog2(NUM_CLASSES);
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS   = CLASS_BITS + PTR_BITS;
   localparam int STORE_DEPTH = NUM_CLASSES * (2 ** PTR_BITS);
   localparam int STORE_BITS  = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [CLASS_BITS-1:0] CLASS_ELDERLY  = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_DISABLED = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_PREGNANT = 2'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_REGULAR  = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_NO_CLASS   = 2'd2,
      STATUS_ALL_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] client_handle;
      logic        is_elderly;
      logic        is_disabled;
      logic        is_pregnant;
      logic        is_regular;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] served_handle;
      logic [1:0]  served_class;
      logic        any_waiting;
   } rsp_type;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_BITS'(1);
      end
      return r;
   endfunction

endpackage

FILE: hdl/four_class_priority_queue_unit.sv
// top level of the four class strict priority queue
//
// usage
//   a command beat is taken at a rising edge with start high and busy low;
//   busy is always low, so a beat can be issued in every cycle
//   req_item.operation selects enqueue or dequeue; an enqueue goes to the
//   queue of the first class flag set (elderly, disabled, pregnant, regular)
//   each command gives exactly one response beat on rsp_item, marked by
//   rsp_valid for one cycle; the receiver cannot stall it
// timing and throughput
//   the command is held in the command register, then passes through the
//   queue update and the store read into the result and read-data registers
//   one command per cycle, set by the single-port store lookup and the
//   per-class pointer update done in one pass
// reset
//   synchronous reset empties all four queues (counts and pointers to zero)
//   and drops any command in flight; the handle store itself is not cleared,
//   entries are only read after being written
module four_class_priority_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fcpq_pkg::req_type req_item,
   output logic              rsp_valid,
   output fcpq_pkg::rsp_type rsp_item
);
   import fcpq_pkg::*;

   // command register
   logic    cmd_valid_ff;
   req_type cmd_ff;

   // per-class queue state
   logic [PTR_BITS-1:0] head_ff  [NUM_CLASSES];
   logic [PTR_BITS-1:0] tail_ff  [NUM_CLASSES];
   logic [CNT_BITS-1:0] count_ff [NUM_CLASSES];
   logic [PTR_BITS-1:0] head_in  [NUM_CLASSES];
   logic [PTR_BITS-1:0] tail_in  [NUM_CLASSES];
   logic [CNT_BITS-1:0] count_in [NUM_CLASSES];

   // handle store, one region per class
   logic [STORE_BITS-1:0] store_mem [STORE_DEPTH];
   logic [STORE_BITS-1:0] rd_data_ff;

   // result register
   logic                  rsp_valid_ff;
   status_type            status_ff;
   logic [CLASS_BITS-1:0] class_ff;
   logic                  waiting_ff;
   logic                  served_ff;

   // pass logic
   logic                  wr_en;
   logic                  rd_en;
   logic [ADDR_BITS-1:0]  mem_addr;
   status_type            status_in;
   logic [CLASS_BITS-1:0] class_in;
   logic                  waiting_in;
   logic                  served_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= start & ~busy;
      end
      if (start & ~busy) begin
         cmd_ff <= req_item;
      end
   end

   always_comb begin
      logic                  found;
      logic [CLASS_BITS-1:0] cls;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      status_in = STATUS_OK;
      class_in  = '0;
      served_in = 1'b0;
      found     = 1'b0;
      cls       = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         head_in[c]  = head_ff[c];
         tail_in[c]  = tail_ff[c];
         count_in[c] = count_ff[c];
      end

      if (cmd_ff.operation == OP_ENQUEUE) begin
         // first set flag in priority order picks the queue
         found = 1'b1;
         if (cmd_ff.is_elderly) begin
            cls = CLASS_ELDERLY;
         end else if (cmd_ff.is_disabled) begin
            cls = CLASS_DISABLED;
         end else if (cmd_ff.is_pregnant) begin
            cls = CLASS_PREGNANT;
         end else if (cmd_ff.is_regular) begin
            cls = CLASS_REGULAR;
         end else begin
            found = 1'b0;
         end
      end else begin
         // highest priority queue that holds an entry
         for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (count_ff[c] != '0) begin
               found = 1'b1;
               cls   = CLASS_BITS'(c);
            end
         end
      end

      mem_addr = (cmd_ff.operation == OP_ENQUEUE) ? {cls, tail_ff[cls]} : {cls, head_ff[cls]};

      if (cmd_ff.operation == OP_ENQUEUE) begin
         if (!found) begin
            status_in = STATUS_NO_CLASS;
         end else begin
            class_in = cls;
            if (count_ff[cls] == CNT_BITS'(QUEUE_DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en         = cmd_valid_ff;
               tail_in[cls]  = next_ptr(tail_ff[cls]);
               count_in[cls] = count_ff[cls] + CNT_BITS'(1);
            end
         end
      end else begin
         if (!found) begin
            status_in = STATUS_ALL_EMPTY;
         end else begin
            class_in      = cls;
            served_in     = 1'b1;
            rd_en         = cmd_valid_ff;
            head_in[cls]  = next_ptr(head_ff[cls]);
            count_in[cls] = count_ff[cls] - CNT_BITS'(1);
         end
      end

      waiting_in = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (count_in[c] != '0) begin
            waiting_in = 1'b1;
         end
      end
   end

   // queue state only moves when a command is in the pass
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else if (cmd_valid_ff) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            count_ff[c] <= count_in[c];
         end
      end
   end

   // handle store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[mem_addr] <= STORE_BITS'(cmd_ff.client_handle);
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_valid_ff;
      end
      status_ff  <= status_in;
      class_ff   <= class_in;
      waiting_ff <= waiting_in;
      served_ff  <= served_in;
   end

   // served handle is zero unless a dequeue took an entry
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_item.status        = status_ff;
   assign rsp_item.served_handle = served_ff ? 16'(rd_data_ff) : 16'd0;
   assign rsp_item.served_class  = 2'(class_ff);
   assign rsp_item.any_waiting   = waiting_ff;

endmodule
